// ----- design/fragment_reassembler_macros.svh -----
// ----------------------------------------------------------------------------
// Fragment reassembler assertion macros
// Clocked, reset-gated assertion shorthands used by the fragment reassembler.
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_REASSEMBLER_MACROS_SVH
`define FRAGMENT_REASSEMBLER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FRA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define FRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/fra_pkg.sv -----
// ----------------------------------------------------------------------------
// Fragment reassembler package
// Field widths, parameter defaults, request codes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package fra_pkg;

	// fixed field widths
	localparam int ID_W     = 3;
	localparam int INDEX_W  = 5;
	localparam int LEN_W    = 7;
	localparam int DATA_W   = 8;
	localparam int STATUS_W = 3;

	// default geometry
	localparam int SOURCES_DEF    = 8;
	localparam int MAX_FRAGS_DEF  = 32;
	localparam int FRAG_BYTES_DEF = 64;

	// generic ram defaults
	localparam int RAM_WIDTH_DEF = DATA_W;
	localparam int RAM_DEPTH_DEF = 256;

	// request function codes
	localparam logic FUNC_FRAG  = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_STORED     = 3'd0,
		ST_WRONG_DEST = 3'd1,
		ST_DUPLICATE  = 3'd2,
		ST_MISSED     = 3'd3,
		ST_READY      = 3'd4,
		ST_BYTE_OUT   = 3'd5,
		ST_NOTHING    = 3'd6,
		ST_BUSY       = 3'd7
	} status_t;

endpackage

`default_nettype wire

// ----- design/fra_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write ram
// One write port and one read port, read data registered under read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module fra_ram #(
	parameter int WIDTH = fra_pkg::RAM_WIDTH_DEF,
	parameter int DEPTH = fra_pkg::RAM_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire             clk,
	input  wire             we,
	input  wire  [AW-1:0]   waddr,
	input  wire  [WIDTH-1:0] wdata,
	input  wire             re,
	input  wire  [AW-1:0]   raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, old data on collision
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- design/fragment_reassembler.sv -----
// ----------------------------------------------------------------------------
// Fragment reassembler
// Rebuilds packets from per-source fragment byte streams and drains them.
//
// Input channel (in_valid/in_ready): one request per byte. func selects a
// fragment byte or a drain of one byte from the ready packet. Output channel
// (out_valid/out_ready): exactly one result per request, in request order.
// own_id is written through cfg_wr_en/cfg_wr_data; the user must do so only
// while the block is idle, and the block itself leaves this unchecked. A request
// passes the request stage, then the result register. Throughput: one request
// per cycle while out_ready holds, set by the single request stage feeding the
// result register; the payload and length rams are read ahead of their use.
// A stalled result holds; the request stage then holds one more request and
// in_ready drops until out_ready returns. Reset clears all contexts, the
// ready flag and own_id; the rams need no clearing since every read entry
// has been written before.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fragment_reassembler_macros.svh"

module fragment_reassembler #(
	parameter int SOURCES    = fra_pkg::SOURCES_DEF,
	parameter int MAX_FRAGS  = fra_pkg::MAX_FRAGS_DEF,
	parameter int FRAG_BYTES = fra_pkg::FRAG_BYTES_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_wr_en,
	input  wire  [fra_pkg::ID_W-1:0]        cfg_wr_data,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire                             func,
	input  wire  [fra_pkg::ID_W-1:0]        src_id,
	input  wire  [fra_pkg::ID_W-1:0]        dest_id,
	input  wire  [fra_pkg::INDEX_W-1:0]     frag_index,
	input  wire  [fra_pkg::LEN_W-1:0]       frag_length,
	input  wire                             last_frag,
	input  wire  [fra_pkg::DATA_W-1:0]      data_byte,
	input  wire                             frag_end,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [fra_pkg::STATUS_W-1:0]    status,
	output logic [fra_pkg::DATA_W-1:0]      out_byte,
	output logic                            out_last,
	output logic [fra_pkg::ID_W-1:0]        out_src
);

	localparam int SW     = (SOURCES > 1) ? $clog2(SOURCES) : 1;
	localparam int FW     = $clog2(MAX_FRAGS);
	localparam int BW     = $clog2(FRAG_BYTES);
	localparam int LW     = $clog2(FRAG_BYTES + 1);
	localparam int CW     = $clog2(MAX_FRAGS + 1);
	localparam int SLOTS  = SOURCES * MAX_FRAGS;
	localparam int SLW    = $clog2(SLOTS);
	localparam int PDEPTH = SLOTS * FRAG_BYTES;
	localparam int PAW    = $clog2(PDEPTH);

	// request stage
	logic                          valid_s1;
	logic                          func_s1;
	logic [fra_pkg::ID_W-1:0]      src_s1;
	logic [fra_pkg::ID_W-1:0]      dest_s1;
	logic [fra_pkg::INDEX_W-1:0]   frag_s1;
	logic [fra_pkg::LEN_W-1:0]     len_s1;
	logic                          last_s1;
	logic [fra_pkg::DATA_W-1:0]    data_s1;
	logic                          fend_s1;

	// handshake
	logic adv;
	logic proc;
	logic in_acc;

	// context state
	logic [fra_pkg::ID_W-1:0] own_id_q;
	logic [MAX_FRAGS-1:0]     present_q  [SOURCES];
	logic [MAX_FRAGS-1:0]     nonempty_q [SOURCES];
	logic [CW-1:0]            count_q    [SOURCES];
	logic [LW-1:0]            byte_pos_q;
	logic                     dup_q;
	logic                     ready_q;
	logic [SW-1:0]            rsrc_q;
	logic [FW-1:0]            dfrag_q;
	logic [BW-1:0]            dbyte_q;

	// result register
	logic                      out_valid_q;
	fra_pkg::status_t          status_q;
	logic [fra_pkg::DATA_W-1:0] obyte_q;
	logic                      olast_q;
	logic [fra_pkg::ID_W-1:0]  osrc_q;

	// decode of the staged request
	logic                 src_ok;
	logic                 in_range;
	logic [SW-1:0]        src_idx;
	logic [FW-1:0]        f_idx;
	logic [MAX_FRAGS-1:0] f_onehot;
	logic [SW-1:0]        sel;
	logic [MAX_FRAGS-1:0] row_present;
	logic [MAX_FRAGS-1:0] row_ne;
	logic [CW-1:0]        row_cnt;
	logic [CW-1:0]        cnt_inc;
	logic                 dup_cur;
	logic [LW-1:0]        bp_inc;
	logic                 pay_wr_ok;
	logic [LW-1:0]        lim_len;
	logic [LW-1:0]        rx_new;
	logic                 commit;
	logic [MAX_FRAGS-1:0] ne_after;
	logic [MAX_FRAGS-1:0] above;
	logic [MAX_FRAGS-1:0] pe_in;
	logic [FW-1:0]        pe_idx;
	logic                 pe_found;
	logic [LW-1:0]        next_byte;

	// ram side
	logic [2*LW-1:0]            len_rdata;
	logic [2*LW-1:0]            len_word;
	logic [LW-1:0]              len_rd;
	logic [LW-1:0]              rxl_rd;
	logic [fra_pkg::DATA_W-1:0] pay_rdata;
	logic [fra_pkg::DATA_W-1:0] pay_rd;
	logic                       len_byp_s1;
	logic [2*LW-1:0]            len_byp_data_s1;
	logic                       pay_byp_s1;
	logic [fra_pkg::DATA_W-1:0] pay_byp_data_s1;
	logic                       len_we;
	logic                       pay_we;
	logic                       len_ram_we;
	logic                       pay_ram_we;
	logic [SLW-1:0]             slot_w;
	logic [SLW-1:0]             slot_r;
	logic [PAW-1:0]             pay_waddr;
	logic [PAW-1:0]             pay_raddr;
	logic [2*LW-1:0]            len_wdata;
	logic [SW-1:0]              rd_src;
	logic [FW-1:0]              rd_frag;
	logic [BW-1:0]              rd_byte;

	// next values
	fra_pkg::status_t           status_n;
	logic [fra_pkg::DATA_W-1:0] obyte_n;
	logic                       olast_n;
	logic [fra_pkg::ID_W-1:0]   osrc_n;
	logic [MAX_FRAGS-1:0]       row_present_n;
	logic [MAX_FRAGS-1:0]       row_ne_n;
	logic [CW-1:0]              cnt_n;
	logic [LW-1:0]              bp_n;
	logic                       dup_n;
	logic                       ready_n;
	logic [SW-1:0]              rsrc_n;
	logic [FW-1:0]              dfrag_n;
	logic [BW-1:0]              dbyte_n;

	// handshake: one request stage in front of the result register
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign in_acc   = in_valid && in_ready;
	assign proc     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1 <= func;
			src_s1  <= src_id;
			dest_s1 <= dest_id;
			frag_s1 <= frag_index;
			len_s1  <= frag_length;
			last_s1 <= last_frag;
			data_s1 <= data_byte;
			fend_s1 <= frag_end;
		end
	end

	// request decode and context row select
	assign src_ok      = 32'(src_s1) < SOURCES;
	assign in_range    = 32'(frag_s1) < MAX_FRAGS;
	assign src_idx     = SW'(src_s1);
	assign f_idx       = FW'(frag_s1);
	assign f_onehot    = MAX_FRAGS'(1) << f_idx;
	assign sel         = (func_s1 == fra_pkg::FUNC_DRAIN) ? rsrc_q : src_idx;
	assign row_present = present_q[sel];
	assign row_ne      = nonempty_q[sel];
	assign row_cnt     = count_q[sel];
	assign cnt_inc     = CW'(32'(row_cnt) + 1);

	// fragment byte path
	assign dup_cur   = (byte_pos_q == '0) ? (!in_range || row_present[f_idx]) : dup_q;
	assign bp_inc    = (32'(byte_pos_q) < FRAG_BYTES) ? LW'(32'(byte_pos_q) + 1) : byte_pos_q;
	assign pay_wr_ok = !dup_cur && in_range && (32'(byte_pos_q) < FRAG_BYTES);
	assign lim_len   = (32'(len_s1) > FRAG_BYTES) ? LW'(FRAG_BYTES) : LW'(len_s1);
	assign rx_new    = (bp_inc < lim_len) ? bp_inc : lim_len;
	assign commit    = !dup_cur && in_range && !row_present[f_idx];
	assign ne_after  = row_ne | ((commit && lim_len != '0) ? f_onehot : '0);

	// fragments above the current drain fragment
	always_comb begin
		for (int i = 0; i < MAX_FRAGS; i++) begin
			above[i] = 32'(i) > 32'(dfrag_q);
		end
	end

	// lowest non-empty fragment: next drain target or first one at ready time
	assign pe_in = (func_s1 == fra_pkg::FUNC_DRAIN) ? (row_ne & above) : ne_after;

	always_comb begin
		pe_idx   = '0;
		pe_found = 1'b0;
		for (int i = MAX_FRAGS - 1; i >= 0; i--) begin
			if (pe_in[i]) begin
				pe_idx   = FW'(i);
				pe_found = 1'b1;
			end
		end
	end

	// ram read data with same-edge write bypass
	assign len_word  = len_byp_s1 ? len_byp_data_s1 : len_rdata;
	assign len_rd    = len_word[2*LW-1:LW];
	assign rxl_rd    = len_word[LW-1:0];
	assign pay_rd    = pay_byp_s1 ? pay_byp_data_s1 : pay_rdata;
	assign next_byte = LW'(32'(dbyte_q) + 1);

	// request processing
	always_comb begin
		status_n      = fra_pkg::ST_NOTHING;
		obyte_n       = '0;
		olast_n       = 1'b0;
		osrc_n        = '0;
		row_present_n = row_present;
		row_ne_n      = row_ne;
		cnt_n         = row_cnt;
		bp_n          = byte_pos_q;
		dup_n         = dup_q;
		ready_n       = ready_q;
		rsrc_n        = rsrc_q;
		dfrag_n       = dfrag_q;
		dbyte_n       = dbyte_q;
		len_we        = 1'b0;
		pay_we        = 1'b0;
		if (func_s1 == fra_pkg::FUNC_DRAIN) begin
			if (ready_q) begin
				osrc_n = fra_pkg::ID_W'(rsrc_q);
				if (row_ne == '0) begin
					// empty packet: freed without a byte
					row_present_n = '0;
					row_ne_n      = '0;
					cnt_n         = '0;
					ready_n       = 1'b0;
					dfrag_n       = '0;
					dbyte_n       = '0;
				end else begin
					status_n = fra_pkg::ST_BYTE_OUT;
					if (LW'(dbyte_q) < rxl_rd) begin
						obyte_n = pay_rd;
					end
					if (next_byte < len_rd) begin
						dbyte_n = BW'(next_byte);
					end else if (pe_found) begin
						dfrag_n = pe_idx;
						dbyte_n = '0;
					end else begin
						// final byte: free the context
						olast_n       = 1'b1;
						row_present_n = '0;
						row_ne_n      = '0;
						cnt_n         = '0;
						ready_n       = 1'b0;
						dfrag_n       = '0;
						dbyte_n       = '0;
					end
				end
			end
		end else if (ready_q) begin
			status_n = fra_pkg::ST_BUSY;
		end else if (dest_s1 != own_id_q || !src_ok) begin
			status_n = fra_pkg::ST_WRONG_DEST;
		end else begin
			status_n = dup_cur ? fra_pkg::ST_DUPLICATE : fra_pkg::ST_STORED;
			pay_we   = pay_wr_ok;
			if (fend_s1) begin
				if (commit) begin
					row_present_n = row_present | f_onehot;
					row_ne_n      = ne_after;
					cnt_n         = cnt_inc;
					len_we        = 1'b1;
				end else begin
					status_n = fra_pkg::ST_DUPLICATE;
				end
				bp_n  = '0;
				dup_n = 1'b0;
				if (last_s1) begin
					osrc_n = src_s1;
					if (32'(cnt_n) != 32'(frag_s1) + 1) begin
						// missing fragments: drop the context
						row_present_n = '0;
						row_ne_n      = '0;
						cnt_n         = '0;
						status_n      = fra_pkg::ST_MISSED;
					end else begin
						ready_n  = 1'b1;
						rsrc_n   = src_idx;
						dfrag_n  = pe_idx;
						dbyte_n  = '0;
						status_n = fra_pkg::ST_READY;
					end
				end
			end else begin
				bp_n  = bp_inc;
				dup_n = dup_cur;
			end
		end
	end

	// context state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q   <= '0;
			for (int i = 0; i < SOURCES; i++) begin
				present_q[i]  <= '0;
				nonempty_q[i] <= '0;
				count_q[i]    <= '0;
			end
			byte_pos_q <= '0;
			dup_q      <= 1'b0;
			ready_q    <= 1'b0;
			rsrc_q     <= '0;
			dfrag_q    <= '0;
			dbyte_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				own_id_q <= cfg_wr_data;
			end
			if (proc) begin
				present_q[sel]  <= row_present_n;
				nonempty_q[sel] <= row_ne_n;
				count_q[sel]    <= cnt_n;
				byte_pos_q      <= bp_n;
				dup_q           <= dup_n;
				ready_q         <= ready_n;
				rsrc_q          <= rsrc_n;
				dfrag_q         <= dfrag_n;
				dbyte_q         <= dbyte_n;
			end
		end
	end

	// ram addressing: reads use the drain position left by the request in flight
	assign rd_src     = proc ? rsrc_n : rsrc_q;
	assign rd_frag    = proc ? dfrag_n : dfrag_q;
	assign rd_byte    = proc ? dbyte_n : dbyte_q;
	assign slot_w     = SLW'(32'(src_idx) * MAX_FRAGS + 32'(f_idx));
	assign slot_r     = SLW'(32'(rd_src) * MAX_FRAGS + 32'(rd_frag));
	assign pay_waddr  = PAW'(32'(slot_w) * FRAG_BYTES + 32'(byte_pos_q));
	assign pay_raddr  = PAW'(32'(slot_r) * FRAG_BYTES + 32'(rd_byte));
	assign len_wdata  = {lim_len, rx_new};
	assign len_ram_we = proc && len_we;
	assign pay_ram_we = proc && pay_we;

	// bypass when the entry read for the next request is written at the same edge
	always_ff @(posedge clk) begin
		if (in_acc) begin
			len_byp_s1      <= len_ram_we && (slot_w == slot_r);
			len_byp_data_s1 <= len_wdata;
			pay_byp_s1      <= pay_ram_we && (pay_waddr == pay_raddr);
			pay_byp_data_s1 <= data_s1;
		end
	end

	// fragment lengths and received counts, one word per slot
	fra_ram #(
		.WIDTH(2 * LW),
		.DEPTH(SLOTS)
	) u_len_ram (
		.clk  (clk),
		.we   (len_ram_we),
		.waddr(slot_w),
		.wdata(len_wdata),
		.re   (in_acc),
		.raddr(slot_r),
		.rdata(len_rdata)
	);

	// payload bytes
	fra_ram #(
		.WIDTH(fra_pkg::DATA_W),
		.DEPTH(PDEPTH)
	) u_pay_ram (
		.clk  (clk),
		.we   (pay_ram_we),
		.waddr(pay_waddr),
		.wdata(data_s1),
		.re   (in_acc),
		.raddr(pay_raddr),
		.rdata(pay_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			status_q <= status_n;
			obyte_q  <= obyte_n;
			olast_q  <= olast_n;
			osrc_q   <= osrc_n;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_byte  = obyte_q;
	assign out_last  = olast_q;
	assign out_src   = osrc_q;

	// checks
	`FRA_ASSERT_NEXT(a_busy_while_ready, proc && func_s1 == fra_pkg::FUNC_FRAG && ready_q, status_q == fra_pkg::ST_BUSY, "fragment request not refused while a packet waits")
	`FRA_ASSERT_IMP(a_last_only_on_byte, out_valid_q && olast_q, status_q == fra_pkg::ST_BYTE_OUT, "last flag on a result that carries no byte")
	`FRA_ASSERT_IMP(a_drain_pos_valid, ready_q && nonempty_q[rsrc_q] != '0, nonempty_q[rsrc_q][dfrag_q], "drain position on an empty or absent fragment")
	`FRA_ASSERT_IMP(a_nonempty_subset, ready_q, (nonempty_q[rsrc_q] & ~present_q[rsrc_q]) == '0, "non-empty fragment without its present bit")

endmodule

`default_nettype wire
